// ----- hw/rtl/alt_pkg.sv -----
// Package for the assembly line tokenizer: request and token structs, token codes,
// character constants and the mnemonic and register keyword tables.
// No dependencies.
package alt_pkg;

    localparam int LINE_COLUMNS_DEF = 256;
    localparam int TOKEN_CHARS_DEF  = 63;

    localparam int NUM_MNEM = 35;
    localparam int NUM_REG  = 16;
    localparam int KW_CHARS = 5;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOL  = 2'd1;
    localparam logic [1:0] KIND_EOI  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam logic [3:0] TT_SYMBOL    = 4'd0;
    localparam logic [3:0] TT_NUMBER    = 4'd1;
    localparam logic [3:0] TT_LABEL     = 4'd2;
    localparam logic [3:0] TT_STRING    = 4'd3;
    localparam logic [3:0] TT_MNEMONIC  = 4'd4;
    localparam logic [3:0] TT_REGISTER  = 4'd5;
    localparam logic [3:0] TT_DIRECTIVE = 4'd6;
    localparam logic [3:0] TT_END       = 4'd7;
    localparam logic [3:0] TT_ERROR     = 4'd8;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] character;
    } t_item;

    typedef struct packed {
        logic [3:0]  token_type;
        logic [7:0]  symbol_char;
        logic [30:0] number_value;
        logic [5:0]  keyword_index;
        logic [7:0]  start_column;
        logic [5:0]  token_length;
        logic        last;
    } t_token;

    typedef enum logic [7:0] {
        M_IDLE      = 8'b0000_0001,
        M_COMMENT   = 8'b0000_0010,
        M_HASH      = 8'b0000_0100,
        M_NUMBER    = 8'b0000_1000,
        M_STRING    = 8'b0001_0000,
        M_IDENT     = 8'b0010_0000,
        M_DIRECTIVE = 8'b0100_0000,
        M_HLABEL    = 8'b1000_0000
    } t_mode;

    // Keywords are left-justified in five bytes, padded with zero bytes.
    localparam logic [39:0] MNEM_TAB [NUM_MNEM] = '{
        {"mov", 16'h0}, {"push", 8'h0}, {"pop", 16'h0}, {"inb", 16'h0},
        {"outb", 8'h0}, {"add", 16'h0}, {"sub", 16'h0}, {"cmp", 16'h0},
        {"inc", 16'h0}, {"dec", 16'h0}, {"mul", 16'h0}, {"div", 16'h0},
        {"and", 16'h0}, {"or", 24'h0},  {"xor", 16'h0}, {"not", 16'h0},
        {"shl", 16'h0}, {"shr", 16'h0}, {"jmp", 16'h0}, {"jz", 24'h0},
        {"jnz", 16'h0}, {"jc", 24'h0},  {"jnc", 16'h0}, {"jo", 24'h0},
        {"jno", 16'h0}, {"jn", 24'h0},  {"jnn", 16'h0}, {"call", 8'h0},
        {"ret", 16'h0}, {"hlt", 16'h0}, {"nop", 16'h0}, {"cli", 16'h0},
        {"sti", 16'h0}, {"int", 16'h0}, {"iret", 8'h0}
    };

    localparam logic [2:0] MNEM_LEN [NUM_MNEM] = '{
        3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2,
        3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd4
    };

    localparam logic [39:0] REG_TAB [NUM_REG] = '{
        {"r0", 24'h0}, {"r1", 24'h0}, {"r2", 24'h0}, {"r3", 24'h0},
        {"r4", 24'h0}, {"r5", 24'h0}, {"r6", 24'h0}, {"r7", 24'h0},
        {"r8", 24'h0}, {"r9", 24'h0}, {"r10", 16'h0}, {"pc", 24'h0},
        {"sp", 24'h0}, {"bp", 24'h0}, {"h", 32'h0},  {"l", 32'h0}
    };

    localparam logic [2:0] REG_LEN [NUM_REG] = '{
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1
    };

endpackage

// ----- hw/rtl/assembly_line_tokenizer.sv -----
// Assembly line tokenizer top level: character state, keyword masks, number
// accumulator and a four-entry token queue. Depends on alt_pkg.
//
// Usage: one request per cycle enters on the item channel (i_item_valid,
// o_item_stall, i_item). A request is a source character, an end of line or
// an end of input. Tokens leave on the token channel (o_token_valid,
// i_token_stall, o_token), one per accepted cycle, with last set on the final
// token that a request causes.
// The tokens of a request are written to the queue at the edge that accepts it
// and appear on o_token once the tokens ahead of them have left the queue.
// Throughput: one request per cycle while o_item_stall is low. A request makes
// zero, one or two tokens; the queue holds four and the item channel stalls
// while more than two are waiting, so a run of two-token requests is limited by
// the one-token-per-cycle output port.
// When the receiver stalls, the head token holds and the queue fills; input
// stalls once fewer than two free entries remain.
// Reset clears the scanner state to idle at column zero and empties the queue.
// An end-of-input request also returns the scanner state to its reset values.
module assembly_line_tokenizer
    import alt_pkg::*;
#(
    parameter int LINE_COLUMNS = LINE_COLUMNS_DEF,
    parameter int TOKEN_CHARS  = TOKEN_CHARS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_item_valid,
    output logic   o_item_stall,
    input  t_item  i_item,
    output logic   o_token_valid,
    input  logic   i_token_stall,
    output t_token o_token
);

    localparam int CW = $clog2(LINE_COLUMNS);
    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam logic [CW-1:0] COL_MAX = CW'(LINE_COLUMNS - 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(TOKEN_CHARS);

    // Scanner state.
    t_mode            r_mode, n_mode;
    logic [CW-1:0]    r_col, n_col;
    logic [CW-1:0]    r_start, n_start;
    logic [LW-1:0]    r_len, n_len;
    logic [30:0]      r_accum, n_accum;
    logic [1:0]       r_radix, n_radix;
    logic             r_frozen, n_frozen;
    logic [NUM_MNEM-1:0] r_mnem, n_mnem;
    logic [NUM_REG-1:0]  r_reg, n_reg;

    // Token queue.
    t_token           r_fifo [4];
    logic [1:0]       r_wr_ptr, r_rd_ptr;
    logic [2:0]       r_count;

    logic [7:0]  c;
    logic        accept, pop;
    logic        is_digit, is_alpha, is_hex, is_space, is_word, is_sym;
    logic [CW-1:0] col_next;
    logic [LW-1:0] len_next;

    t_token      flush_tok;
    logic        flush_has;
    logic        found;

    logic [NUM_MNEM-1:0] feed_mnem, first_mnem;
    logic [NUM_REG-1:0]  feed_reg, first_reg;
    logic [2:0]  pos;

    logic [4:0]  dig;
    logic [4:0]  base;
    logic [35:0] prod;
    logic [30:0] dig_accum;
    logic        dig_frozen;

    t_token      res [2];
    logic [1:0]  cnt;
    logic        do_flush, do_start;

    function automatic t_token make_tok(logic [3:0] tt, logic [7:0] sym, logic [30:0] val,
                                        logic [5:0] kidx, logic [7:0] col, logic [5:0] len);
        t_token t;
        t.token_type    = tt;
        t.symbol_char   = sym;
        t.number_value  = val;
        t.keyword_index = kidx;
        t.start_column  = col;
        t.token_length  = len;
        t.last          = 1'b0;
        return t;
    endfunction

    assign c        = i_item.character;
    assign accept   = i_item_valid && !o_item_stall;
    assign pop      = o_token_valid && !i_token_stall;
    assign o_item_stall  = (r_count > 3'd2);
    assign o_token_valid = (r_count != 3'd0);
    assign o_token       = r_fifo[r_rd_ptr];

    assign is_digit = (c >= "0") && (c <= "9");
    assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_hex   = is_digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    assign is_word  = is_alpha || is_digit || (c == CH_UNDER);
    assign is_sym   = (c == ",") || (c == ":") || (c == "(") || (c == ")") || (c == "[") ||
                      (c == "]") || (c == "+") || (c == "-") || (c == "=");

    assign col_next = (r_col < COL_MAX) ? r_col + CW'(1) : COL_MAX;
    assign len_next = (r_len < LEN_MAX) ? r_len + LW'(1) : LEN_MAX;

    // Per-position keyword masks: a keyword stays alive while each character matches.
    always_comb begin
        pos = r_len[2:0];
        for (int k = 0; k < NUM_MNEM; k++) begin
            feed_mnem[k]  = r_mnem[k] && (r_len < LW'(KW_CHARS)) &&
                            (MNEM_TAB[k][39 - 8*pos -: 8] == c);
            first_mnem[k] = (MNEM_TAB[k][39:32] == c);
        end
        for (int k = 0; k < NUM_REG; k++) begin
            feed_reg[k]  = r_reg[k] && (r_len < LW'(KW_CHARS)) &&
                           (REG_TAB[k][39 - 8*pos -: 8] == c);
            first_reg[k] = (REG_TAB[k][39:32] == c);
        end
    end

    // Digit accumulation; multiplying by 2, 10 or 16 is a shift and add.
    always_comb begin
        dig  = is_digit ? 5'(c - "0") : 5'((c | 8'h20) - "a" + 8'd10);
        base = (r_radix == RADIX_HEX) ? 5'd16 : ((r_radix == RADIX_BIN) ? 5'd2 : 5'd10);
        unique case (r_radix)
            RADIX_HEX: prod = {r_accum, 4'b0} + 36'(dig);
            RADIX_BIN: prod = {4'b0, r_accum, 1'b0} + 36'(dig);
            default:   prod = {2'b0, r_accum, 3'b0} + {4'b0, r_accum, 1'b0} + 36'(dig);
        endcase
        dig_accum  = r_accum;
        dig_frozen = r_frozen;
        if (!r_frozen) begin
            if (dig >= base) begin
                dig_frozen = 1'b1;
            end else begin
                dig_accum = (prod > 36'(VALUE_MAX)) ? VALUE_MAX : prod[30:0];
            end
        end
    end

    // The token that closes the pending one, built from the current state only.
    always_comb begin
        flush_tok = make_tok(TT_LABEL, 8'd0, 31'd0, 6'd0, 8'(r_start), 6'(r_len));
        flush_has = 1'b1;
        found     = 1'b0;
        unique case (r_mode)
            M_HASH:      flush_tok = make_tok(TT_ERROR, 8'd0, 31'd0, 6'd0, 8'(r_start), 6'd0);
            M_NUMBER:    flush_tok = make_tok(TT_NUMBER, 8'd0, r_accum, 6'd0, 8'(r_start), 6'd0);
            M_STRING:    flush_tok.token_type = TT_STRING;
            M_DIRECTIVE: flush_tok.token_type = TT_DIRECTIVE;
            M_HLABEL:    flush_tok.token_type = TT_LABEL;
            M_IDENT: begin
                for (int k = 0; k < NUM_MNEM; k++) begin
                    if (!found && r_mnem[k] && (r_len == LW'(MNEM_LEN[k]))) begin
                        found = 1'b1;
                        flush_tok.token_type    = TT_MNEMONIC;
                        flush_tok.keyword_index = 6'(k);
                    end
                end
                for (int k = 0; k < NUM_REG; k++) begin
                    if (!found && r_reg[k] && (r_len == LW'(REG_LEN[k]))) begin
                        found = 1'b1;
                        flush_tok.token_type    = TT_REGISTER;
                        flush_tok.keyword_index = 6'(k);
                    end
                end
            end
            default:     flush_has = 1'b0;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_col    = r_col;
        n_start  = r_start;
        n_len    = r_len;
        n_accum  = r_accum;
        n_radix  = r_radix;
        n_frozen = r_frozen;
        n_mnem   = r_mnem;
        n_reg    = r_reg;
        res[0]   = '0;
        res[1]   = '0;
        cnt      = 2'd0;
        do_flush = 1'b0;
        do_start = 1'b0;

        if (accept && (i_item.kind == KIND_CHAR)) begin
            unique case (r_mode)
                M_COMMENT: ;
                M_STRING: begin
                    if (c == CH_QUOTE) do_flush = 1'b1;
                    else n_len = len_next;
                end
                M_NUMBER: begin
                    if (is_hex) begin
                        n_accum  = dig_accum;
                        n_frozen = dig_frozen;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word || (c == CH_DOT)) begin
                        n_mnem = feed_mnem;
                        n_reg  = feed_reg;
                        n_len  = len_next;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_DIRECTIVE: begin
                    if (is_word || (c == CH_DOT)) n_len = len_next;
                    else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_HLABEL: begin
                    if (is_word) n_len = len_next;
                    else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_HASH: begin
                    if ((c == CH_DOLLAR) || (c == CH_PCT)) begin
                        n_mode   = M_NUMBER;
                        n_radix  = (c == CH_DOLLAR) ? RADIX_HEX : RADIX_BIN;
                        n_accum  = 31'd0;
                        n_frozen = 1'b0;
                        n_start  = col_next;
                    end else if (is_digit) begin
                        n_mode   = M_NUMBER;
                        n_radix  = RADIX_DEC;
                        n_accum  = 31'(c - "0");
                        n_frozen = 1'b0;
                        n_start  = r_col;
                    end else if (is_alpha) begin
                        n_mode  = M_HLABEL;
                        n_len   = LW'(1);
                        n_start = r_col;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
            n_col = col_next;
        end else if (accept && ((i_item.kind == KIND_EOL) || (i_item.kind == KIND_EOI))) begin
            do_flush = 1'b1;
            n_col    = '0;
        end

        if (do_flush) begin
            n_mode = M_IDLE;
            if (flush_has) begin
                res[cnt[0]] = flush_tok;
                cnt = cnt + 2'd1;
            end
        end

        if (do_start) begin
            n_mode = M_IDLE;
            if (is_space) begin
                n_mode = M_IDLE;
            end else if (c == CH_SEMI) begin
                n_mode = M_COMMENT;
            end else if (is_sym || (c == CH_HASH) || (c == CH_DOLLAR) || (c == CH_PCT)) begin
                res[cnt[0]] = make_tok(TT_SYMBOL, c, 31'd0, 6'd0, 8'(r_col), 6'd0);
                cnt = cnt + 2'd1;
                if (c == CH_HASH) begin
                    n_mode  = M_HASH;
                    n_start = r_col;
                end else if ((c == CH_DOLLAR) || (c == CH_PCT)) begin
                    n_mode   = M_NUMBER;
                    n_radix  = (c == CH_DOLLAR) ? RADIX_HEX : RADIX_BIN;
                    n_accum  = 31'd0;
                    n_frozen = 1'b0;
                    n_start  = col_next;
                end
            end else if (is_digit) begin
                n_mode   = M_NUMBER;
                n_radix  = RADIX_DEC;
                n_accum  = 31'(c - "0");
                n_frozen = 1'b0;
                n_start  = r_col;
            end else if (c == CH_QUOTE) begin
                n_mode  = M_STRING;
                n_len   = '0;
                n_start = col_next;
            end else if (is_alpha) begin
                n_mode  = M_IDENT;
                n_mnem  = first_mnem;
                n_reg   = first_reg;
                n_len   = LW'(1);
                n_start = r_col;
            end else if (c == CH_DOT) begin
                n_mode  = M_DIRECTIVE;
                n_len   = LW'(1);
                n_start = r_col;
            end
        end

        // End of input closes the line, adds the end token and restores reset state.
        if (accept && (i_item.kind == KIND_EOI)) begin
            res[cnt[0]] = make_tok(TT_END, 8'd0, 31'd0, 6'd0, 8'd0, 6'd0);
            cnt      = cnt + 2'd1;
            n_mode   = M_IDLE;
            n_start  = '0;
            n_len    = '0;
            n_accum  = '0;
            n_radix  = RADIX_DEC;
            n_frozen = 1'b0;
            n_mnem   = '1;
            n_reg    = '1;
        end

        if (cnt != 2'd0) begin
            res[1'(cnt - 2'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_col    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_accum  <= '0;
            r_radix  <= RADIX_DEC;
            r_frozen <= 1'b0;
            r_mnem   <= '1;
            r_reg    <= '1;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_col    <= n_col;
            r_start  <= n_start;
            r_len    <= n_len;
            r_accum  <= n_accum;
            r_radix  <= n_radix;
            r_frozen <= n_frozen;
            r_mnem   <= n_mnem;
            r_reg    <= n_reg;
            r_wr_ptr <= r_wr_ptr + cnt;
            r_rd_ptr <= r_rd_ptr + 2'(pop);
            r_count  <= r_count + 3'(cnt) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res[0];
        end
        if (cnt == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= res[1];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("token queue count out of range");

    a_eoi_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.kind == KIND_EOI) |=> (r_mode == M_IDLE) && (r_col == '0))
        else $error("end of input did not return scanner to idle");

    a_eoi_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.kind == KIND_EOI) |=> r_count != 3'd0)
        else $error("end of input produced no token");

    a_none_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.kind == KIND_NONE) && !pop |=> $stable(r_count))
        else $error("unused request kind changed the queue");

endmodule
